@@ sv/ipaf_pkg.sv @@
// Package for the IP address packet filter: item structs, register indexes,
// link, kind and mode codes, and header constants. No dependencies.
package ipaf_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        keep;
    logic [1:0]  ip_kind;
    logic [31:0] kept_total;
  } out_item_t;

  // Pattern addresses as written through the configuration port.
  typedef struct packed {
    logic [31:0] v4_a;
    logic [31:0] v4_b;
    logic [63:0] v6_a_high;
    logic [63:0] v6_a_low;
    logic [63:0] v6_b_high;
    logic [63:0] v6_b_low;
  } pattern_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LINK_TYPE   = 3'd0;
  localparam logic [2:0] CFG_FILTER_MODE = 3'd1;
  localparam logic [2:0] CFG_V4_A        = 3'd2;
  localparam logic [2:0] CFG_V4_B        = 3'd3;
  localparam logic [2:0] CFG_V6_A_HIGH   = 3'd4;
  localparam logic [2:0] CFG_V6_A_LOW    = 3'd5;
  localparam logic [2:0] CFG_V6_B_HIGH   = 3'd6;
  localparam logic [2:0] CFG_V6_B_LOW    = 3'd7;

  // Link types.
  localparam logic [1:0] LINK_NULL = 2'd0;
  localparam logic [1:0] LINK_ETH  = 2'd1;

  // IP kinds, also used as the protocol class of the current frame.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_V4   = 2'd1;
  localparam logic [1:0] KIND_V6   = 2'd2;

  // Filter modes.
  localparam logic [2:0] MODE_ANY     = 3'd0;
  localparam logic [2:0] MODE_V4      = 3'd1;
  localparam logic [2:0] MODE_V6      = 3'd2;
  localparam logic [2:0] MODE_V4_ONE  = 3'd3;
  localparam logic [2:0] MODE_V4_PAIR = 3'd4;
  localparam logic [2:0] MODE_V6_ONE  = 3'd5;
  localparam logic [2:0] MODE_V6_PAIR = 3'd6;

  // Link header identifiers and lengths.
  localparam logic [31:0] FAM_V4 = 32'h0200_0000;
  localparam logic [31:0] FAM_V6 = 32'h0180_0000;
  localparam logic [15:0] ETH_V4 = 16'h0800;
  localparam logic [15:0] ETH_V6 = 16'h86dd;

  localparam logic [5:0] HDR_NULL = 6'd4;
  localparam logic [5:0] HDR_ETH  = 6'd14;
  localparam logic [5:0] IP4_HDR  = 6'd20;
  localparam logic [5:0] IP6_HDR  = 6'd40;
  localparam logic [5:0] POS_MAX  = 6'd63;

endpackage

@@ sv/ip_packet_address_filter_unit.sv @@
// Top level of the IP address packet filter: configuration registers, byte
// parser, kept counter and result register. Depends on ipaf_pkg, ipaf_verdict.
//
// The filter takes one frame byte per clock with no gaps needed between frames.
// Each accepted byte updates the link header shift register, the protocol class
// and the captured source and destination addresses in the same cycle; on the
// byte marked as frame end the verdict is computed and loaded into the result
// register, so a result appears in the cycle after its last byte. The only stall
// comes from the result register: input is held off while a result is waiting
// and out_stall is high. Configuration writes are always taken (cfg_ready is
// tied high) and should only be made between frames.
module ip_packet_address_filter_unit import ipaf_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

  logic [1:0]  link_type_r;
  logic [2:0]  filter_mode_r;
  pattern_t    pattern_r;

  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] type_r, type_nxt;
  logic [1:0]  class_r, class_nxt;
  logic [63:0] src_high_r, src_high_nxt, src_low_r, src_low_nxt;
  logic [63:0] dst_high_r, dst_high_nxt, dst_low_r, dst_low_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        in_acc;
  logic        link_ok;
  logic [5:0]  hdr;
  logic [5:0]  off;
  logic [7:0]  b;
  logic [1:0]  kind;
  logic        keep;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign b       = in_item.frame_byte;
  assign link_ok = (link_type_r == LINK_NULL) || (link_type_r == LINK_ETH);
  assign hdr     = (link_type_r == LINK_NULL) ? HDR_NULL : HDR_ETH;
  assign off     = pos_r - hdr;

  always_comb begin
    type_nxt     = type_r;
    class_nxt    = class_r;
    src_high_nxt = src_high_r;
    src_low_nxt  = src_low_r;
    dst_high_nxt = dst_high_r;
    dst_low_nxt  = dst_low_r;
    if (link_ok) begin
      if (pos_r < hdr) begin
        type_nxt = {type_r[23:0], b};
        // The link header is classified on its final byte.
        if (pos_r == hdr - 6'd1) begin
          class_nxt = KIND_NONE;
          if (link_type_r == LINK_NULL) begin
            if (type_nxt == FAM_V4)      class_nxt = KIND_V4;
            else if (type_nxt == FAM_V6) class_nxt = KIND_V6;
          end else begin
            if (type_nxt[15:0] == ETH_V4)      class_nxt = KIND_V4;
            else if (type_nxt[15:0] == ETH_V6) class_nxt = KIND_V6;
          end
        end
      end else if (class_r == KIND_V4) begin
        if (off >= 6'd12 && off < 6'd16) begin
          src_low_nxt = {32'd0, src_low_r[23:0], b};
        end else if (off >= 6'd16 && off < 6'd20) begin
          dst_low_nxt = {32'd0, dst_low_r[23:0], b};
        end
      end else if (class_r == KIND_V6) begin
        if (off >= 6'd8 && off < 6'd16) begin
          src_high_nxt = {src_high_r[55:0], b};
        end else if (off >= 6'd16 && off < 6'd24) begin
          src_low_nxt = {src_low_r[55:0], b};
        end else if (off >= 6'd24 && off < 6'd32) begin
          dst_high_nxt = {dst_high_r[55:0], b};
        end else if (off >= 6'd32 && off < 6'd40) begin
          dst_low_nxt = {dst_low_r[55:0], b};
        end
      end
    end
  end

  assign pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 6'd1;

  // A frame only counts as IP if the whole IP header arrived.
  always_comb begin
    kind = KIND_NONE;
    if (link_ok) begin
      if (class_nxt == KIND_V4 && pos_nxt >= hdr + IP4_HDR) begin
        kind = KIND_V4;
      end else if (class_nxt == KIND_V6 && pos_nxt >= hdr + IP6_HDR) begin
        kind = KIND_V6;
      end
    end
  end

  ipaf_verdict u_verdict (
    .filter_mode (filter_mode_r),
    .ip_kind     (kind),
    .pattern     (pattern_r),
    .src_high    (src_high_nxt),
    .src_low     (src_low_nxt),
    .dst_high    (dst_high_nxt),
    .dst_low     (dst_low_nxt),
    .keep        (keep)
  );

  assign cnt_nxt = keep ? cnt_r + CntOne : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_type_r   <= LINK_ETH;
      filter_mode_r <= MODE_ANY;
      pattern_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LINK_TYPE:   link_type_r         <= cfg_data[1:0];
        CFG_FILTER_MODE: filter_mode_r       <= cfg_data[2:0];
        CFG_V4_A:        pattern_r.v4_a      <= cfg_data[31:0];
        CFG_V4_B:        pattern_r.v4_b      <= cfg_data[31:0];
        CFG_V6_A_HIGH:   pattern_r.v6_a_high <= cfg_data;
        CFG_V6_A_LOW:    pattern_r.v6_a_low  <= cfg_data;
        CFG_V6_B_HIGH:   pattern_r.v6_b_high <= cfg_data;
        CFG_V6_B_LOW:    pattern_r.v6_b_low  <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      type_r     <= '0;
      class_r    <= KIND_NONE;
      src_high_r <= '0;
      src_low_r  <= '0;
      dst_high_r <= '0;
      dst_low_r  <= '0;
      cnt_r      <= '0;
    end else if (in_acc) begin
      if (in_item.frame_end) begin
        // Per-frame state starts over after every result.
        pos_r      <= '0;
        type_r     <= '0;
        class_r    <= KIND_NONE;
        src_high_r <= '0;
        src_low_r  <= '0;
        dst_high_r <= '0;
        dst_low_r  <= '0;
        cnt_r      <= cnt_nxt;
      end else begin
        pos_r      <= pos_nxt;
        type_r     <= type_nxt;
        class_r    <= class_nxt;
        src_high_r <= src_high_nxt;
        src_low_r  <= src_low_nxt;
        dst_high_r <= dst_high_nxt;
        dst_low_r  <= dst_low_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_item.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_item.frame_end) begin
      out_item_r.keep       <= keep;
      out_item_r.ip_kind    <= kind;
      out_item_r.kept_total <= 32'(cnt_nxt);
    end
  end

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.frame_end) |=> out_valid_r)
    else $error("frame end accepted without a result");

  a_keep_needs_ip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.keep) |-> (out_item_r.ip_kind != KIND_NONE))
    else $error("kept frame without IP kind");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.frame_end) |=> (pos_r == '0 && class_r == KIND_NONE))
    else $error("frame state not cleared after frame end");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.frame_end && keep) |=> (cnt_r == $past(cnt_r) + CntOne))
    else $error("kept counter did not advance");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_item.frame_end) |=> $stable(cnt_r))
    else $error("kept counter moved without a frame end");

endmodule

@@ sv/ipaf_verdict.sv @@
// Keep/drop decision for one frame from its IP kind, captured addresses and
// the filter mode. Depends on ipaf_pkg.
module ipaf_verdict import ipaf_pkg::*; (
  input  logic [2:0]  filter_mode,
  input  logic [1:0]  ip_kind,
  input  pattern_t    pattern,
  input  logic [63:0] src_high,
  input  logic [63:0] src_low,
  input  logic [63:0] dst_high,
  input  logic [63:0] dst_low,
  output logic        keep
);

  logic sa4, da4, sb4, db4;
  logic sa6, da6, sb6, db6;
  logic is_v4, is_v6;

  // An IPv4 address lives in the low half with the upper half zero.
  assign sa4 = (src_low == {32'd0, pattern.v4_a});
  assign da4 = (dst_low == {32'd0, pattern.v4_a});
  assign sb4 = (src_low == {32'd0, pattern.v4_b});
  assign db4 = (dst_low == {32'd0, pattern.v4_b});

  assign sa6 = (src_high == pattern.v6_a_high) && (src_low == pattern.v6_a_low);
  assign da6 = (dst_high == pattern.v6_a_high) && (dst_low == pattern.v6_a_low);
  assign sb6 = (src_high == pattern.v6_b_high) && (src_low == pattern.v6_b_low);
  assign db6 = (dst_high == pattern.v6_b_high) && (dst_low == pattern.v6_b_low);

  assign is_v4 = (ip_kind == KIND_V4);
  assign is_v6 = (ip_kind == KIND_V6);

  always_comb begin
    unique case (filter_mode)
      MODE_ANY:     keep = (ip_kind != KIND_NONE);
      MODE_V4:      keep = is_v4;
      MODE_V6:      keep = is_v6;
      MODE_V4_ONE:  keep = is_v4 && (sa4 || da4);
      MODE_V4_PAIR: keep = is_v4 && ((sa4 && db4) || (sb4 && da4));
      MODE_V6_ONE:  keep = is_v6 && (sa6 || da6);
      MODE_V6_PAIR: keep = is_v6 && ((sa6 && db6) || (sb6 && da6));
      default:      keep = 1'b0;
    endcase
  end

endmodule

@@ tb/sv/ipaf_checker.sv @@
`timescale 1ns / 100ps
// Checker for the IP address packet filter: watches the byte, result and
// configuration channels, predicts each verdict and compares it field by field.
// Depends on ipaf_pkg.
module ipaf_checker import ipaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          error_count,
  output int          pending
);

  // Register copies.
  logic [1:0]  link_type;
  logic [2:0]  filter_mode;
  pattern_t    pat;

  // Per-frame parse state.
  logic [5:0]  byte_count;
  logic [31:0] link_word;
  logic [1:0]  frame_class;
  logic [63:0] src_high, src_low, dst_high, dst_low;
  logic [31:0] kept_frames;

  out_item_t   verdict_q[$];

  task automatic clear_frame();
    byte_count  = '0;
    link_word   = '0;
    frame_class = KIND_NONE;
    src_high    = '0;
    src_low     = '0;
    dst_high    = '0;
    dst_low     = '0;
  endtask

  function automatic logic [1:0] class_of(input logic [1:0] lt, input logic [31:0] w);
    class_of = KIND_NONE;
    if (lt == LINK_NULL) begin
      if (w == FAM_V4) class_of = KIND_V4;
      else if (w == FAM_V6) class_of = KIND_V6;
    end else begin
      if (w[15:0] == ETH_V4) class_of = KIND_V4;
      else if (w[15:0] == ETH_V6) class_of = KIND_V6;
    end
  endfunction

  // Offsets are counted from the start of the IP header.
  task automatic grab_address(input logic [5:0] off, input logic [7:0] b);
    if (frame_class == KIND_V4) begin
      if (off >= 12 && off < 16) src_low = {32'd0, src_low[23:0], b};
      else if (off >= 16 && off < 20) dst_low = {32'd0, dst_low[23:0], b};
    end else if (frame_class == KIND_V6) begin
      if (off >= 8 && off < 16) src_high = {src_high[55:0], b};
      else if (off >= 16 && off < 24) src_low = {src_low[55:0], b};
      else if (off >= 24 && off < 32) dst_high = {dst_high[55:0], b};
      else if (off >= 32 && off < 40) dst_low = {dst_low[55:0], b};
    end
  endtask

  function automatic logic keep_for(input logic [1:0] kind);
    logic sa4, da4, sb4, db4, sa6, da6, sb6, db6;
    sa4 = src_low == {32'd0, pat.v4_a};
    da4 = dst_low == {32'd0, pat.v4_a};
    sb4 = src_low == {32'd0, pat.v4_b};
    db4 = dst_low == {32'd0, pat.v4_b};
    sa6 = {src_high, src_low} == {pat.v6_a_high, pat.v6_a_low};
    da6 = {dst_high, dst_low} == {pat.v6_a_high, pat.v6_a_low};
    sb6 = {src_high, src_low} == {pat.v6_b_high, pat.v6_b_low};
    db6 = {dst_high, dst_low} == {pat.v6_b_high, pat.v6_b_low};
    case (filter_mode)
      MODE_ANY:     keep_for = kind != KIND_NONE;
      MODE_V4:      keep_for = kind == KIND_V4;
      MODE_V6:      keep_for = kind == KIND_V6;
      MODE_V4_ONE:  keep_for = kind == KIND_V4 && (sa4 || da4);
      MODE_V4_PAIR: keep_for = kind == KIND_V4 && ((sa4 && db4) || (sb4 && da4));
      MODE_V6_ONE:  keep_for = kind == KIND_V6 && (sa6 || da6);
      MODE_V6_PAIR: keep_for = kind == KIND_V6 && ((sa6 && db6) || (sb6 && da6));
      default:      keep_for = 1'b0;
    endcase
  endfunction

  task automatic take_byte(input in_item_t it);
    logic [5:0] hdr_len;
    logic [1:0] kind;
    out_item_t  res;
    hdr_len = (link_type == LINK_NULL) ? HDR_NULL : HDR_ETH;
    if (link_type <= LINK_ETH) begin
      if (byte_count < hdr_len) begin
        link_word = {link_word[23:0], it.frame_byte};
        if (byte_count == hdr_len - 1) frame_class = class_of(link_type, link_word);
      end else begin
        grab_address(byte_count - hdr_len, it.frame_byte);
      end
    end
    if (byte_count < POS_MAX) byte_count++;
    if (it.frame_end) begin
      kind = KIND_NONE;
      if (link_type <= LINK_ETH) begin
        if (frame_class == KIND_V4 && byte_count >= hdr_len + IP4_HDR) kind = KIND_V4;
        else if (frame_class == KIND_V6 && byte_count >= hdr_len + IP6_HDR) kind = KIND_V6;
      end
      res.keep    = keep_for(kind);
      res.ip_kind = kind;
      if (res.keep) kept_frames++;
      res.kept_total = kept_frames;
      verdict_q.push_back(res);
      clear_frame();
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      $display("%0t: expected no result, actual keep=%0d kind=%0d total=%0d",
               $time, got.keep, got.ip_kind, got.kept_total);
      error_count++;
    end else begin
      want = verdict_q.pop_front();
      if (got.keep !== want.keep) begin
        $display("%0t: keep expected %0d, actual %0d", $time, want.keep, got.keep);
        error_count++;
      end
      if (got.ip_kind !== want.ip_kind) begin
        $display("%0t: ip_kind expected %0d, actual %0d", $time, want.ip_kind, got.ip_kind);
        error_count++;
      end
      if (got.kept_total !== want.kept_total) begin
        $display("%0t: kept_total expected %0d, actual %0d",
                 $time, want.kept_total, got.kept_total);
        error_count++;
      end
    end
  endtask

  task automatic apply_write(input logic [2:0] idx, input logic [63:0] data);
    case (idx)
      CFG_LINK_TYPE:   link_type = data[1:0];
      CFG_FILTER_MODE: filter_mode = data[2:0];
      CFG_V4_A:        pat.v4_a = data[31:0];
      CFG_V4_B:        pat.v4_b = data[31:0];
      CFG_V6_A_HIGH:   pat.v6_a_high = data;
      CFG_V6_A_LOW:    pat.v6_a_low = data;
      CFG_V6_B_HIGH:   pat.v6_b_high = data;
      CFG_V6_B_LOW:    pat.v6_b_low = data;
      default: ;
    endcase
  endtask

  // A byte taken at an edge is parsed with the registers in force before
  // any write at that same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      link_type   = LINK_ETH;
      filter_mode = MODE_ANY;
      pat         = '0;
      kept_frames = '0;
      clear_frame();
      verdict_q.delete();
    end else begin
      if (in_valid && !in_stall) take_byte(in_item);
      if (out_valid && !out_stall) check_result(out_item);
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
    end
    pending = verdict_q.size();
  end

endmodule

@@ tb/sv/tb_ip_packet_address_filter_unit.sv @@
`timescale 1ns / 100ps
// Top of the IP address packet filter testbench: clock, reset, frame stimulus,
// register setup and the verdict. Depends on ipaf_pkg, ipaf_checker and the block.
module tb_ip_packet_address_filter_unit import ipaf_pkg::*; ();

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASES      = 12;
  localparam int         PHASE_BYTES = 120;
  // Link header announcing something that is neither IPv4 nor IPv6.
  localparam logic [1:0] PROTO_OTHER = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = CFG_LINK_TYPE;
  logic [63:0] cfg_data = '0;
  logic        in_stall, out_valid, cfg_ready;
  out_item_t   out_item;
  int          error_count, pending;

  logic        tx_gaps = 1'b0;
  logic        rx_gaps = 1'b0;
  int          stall_left = 0;
  int          sent_bytes = 0;
  logic [1:0]  cur_link = LINK_ETH;
  pattern_t    cur_pat = '0;
  logic [7:0]  frame_q[$];

  ip_packet_address_filter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ipaf_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .pending     (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side back-pressure: stalls come in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (rx_gaps && !out_stall && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // All channel tasks start right after a rising edge and return at one.
  task automatic push_byte(input logic [7:0] b, input logic last);
    logic took;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_item.frame_byte <= b;
    in_item.frame_end  <= last;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    sent_bytes++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_bytes(input logic [127:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) frame_q.push_back(v[i*8 +: 8]);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic build_frame(input logic [1:0] framing, input logic [1:0] proto,
                             input logic [127:0] src, input logic [127:0] dst,
                             input int len);
    logic [31:0] ident;
    if (framing == LINK_NULL) begin
      ident = (proto == KIND_V4) ? FAM_V4 : (proto == KIND_V6) ? FAM_V6 : $urandom;
      put_bytes(128'(ident), 4);
    end else begin
      repeat (12) frame_q.push_back(8'($urandom));
      ident = (proto == KIND_V4) ? 32'(ETH_V4) : (proto == KIND_V6) ? 32'(ETH_V6) : $urandom;
      put_bytes(128'(ident), 2);
    end
    if (proto == KIND_V4) begin
      frame_q.push_back(8'h45);
      repeat (11) frame_q.push_back(8'($urandom));
      put_bytes(src, 4);
      put_bytes(dst, 4);
    end else if (proto == KIND_V6) begin
      frame_q.push_back(8'h60);
      repeat (7) frame_q.push_back(8'($urandom));
      put_bytes(src, 16);
      put_bytes(dst, 16);
    end
    while (frame_q.size() < len) frame_q.push_back(8'($urandom));
    while (frame_q.size() > len) void'(frame_q.pop_back());
  endtask

  // Mostly the pattern addresses, so that the address modes see hits.
  function automatic logic [127:0] pick_addr(input logic [127:0] a, input logic [127:0] b,
                                             input int bits);
    case ($urandom_range(0, 7))
      0, 1, 2: pick_addr = a;
      3, 4:    pick_addr = b;
      5:       pick_addr = a ^ (128'd1 << $urandom_range(0, bits - 1));
      6:       pick_addr = $urandom_range(0, 1) ? '1 : '0;
      default: pick_addr = {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  task automatic random_frame();
    logic [1:0]   framing, proto;
    logic [127:0] a, b;
    int           pick, bits, full, len;
    framing = (cur_link <= LINK_ETH) ? cur_link : 2'($urandom_range(0, 1));
    pick = $urandom_range(0, 19);
    proto = (pick < 9) ? KIND_V4 : (pick < 17) ? KIND_V6 : PROTO_OTHER;
    if (proto == KIND_V6) begin
      a    = {cur_pat.v6_a_high, cur_pat.v6_a_low};
      b    = {cur_pat.v6_b_high, cur_pat.v6_b_low};
      bits = 128;
    end else begin
      a    = {96'd0, cur_pat.v4_a};
      b    = {96'd0, cur_pat.v4_b};
      bits = 32;
    end
    full = (framing == LINK_NULL) ? HDR_NULL : HDR_ETH;
    if (proto == KIND_V4) full += IP4_HDR;
    else if (proto == KIND_V6) full += IP6_HDR;
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(1, full - 1);
      1:       len = $urandom_range(full, 80);
      default: len = full + $urandom_range(0, 3);
    endcase
    build_frame(framing, proto, pick_addr(a, b, bits), pick_addr(a, b, bits), len);
    send_frame();
  endtask

  function automatic logic [63:0] pattern_word(input int style);
    case (style)
      0: pattern_word = '0;
      1: pattern_word = '1;
      default: begin
        case ($urandom_range(0, 5))
          0:       pattern_word = '0;
          1:       pattern_word = '1;
          default: pattern_word = {$urandom, $urandom};
        endcase
      end
    endcase
  endfunction

  // Unused upper bits of the narrow registers carry random data.
  task automatic configure(input logic [1:0] lt, input logic [2:0] md, input int style);
    logic [63:0] v4a, v4b;
    v4a = pattern_word(style);
    v4b = pattern_word(style);
    cur_link          = lt;
    cur_pat.v4_a      = v4a[31:0];
    cur_pat.v4_b      = v4b[31:0];
    cur_pat.v6_a_high = pattern_word(style);
    cur_pat.v6_a_low  = pattern_word(style);
    cur_pat.v6_b_high = pattern_word(style);
    cur_pat.v6_b_low  = pattern_word(style);
    write_reg(CFG_LINK_TYPE, {$urandom, 30'($urandom), lt});
    write_reg(CFG_FILTER_MODE, {$urandom, 29'($urandom), md});
    write_reg(CFG_V4_A, {$urandom, cur_pat.v4_a});
    write_reg(CFG_V4_B, {$urandom, cur_pat.v4_b});
    write_reg(CFG_V6_A_HIGH, cur_pat.v6_a_high);
    write_reg(CFG_V6_A_LOW, cur_pat.v6_a_low);
    write_reg(CFG_V6_B_HIGH, cur_pat.v6_b_high);
    write_reg(CFG_V6_B_LOW, cur_pat.v6_b_low);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int         budget, style;
    logic [1:0] lt;
    logic [2:0] md;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: Ethernet, any IP. One-byte frames, then an IPv4 frame of
    // exactly full length and one a byte too short.
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    frame_q.push_back(8'h00);
    send_frame();
    frame_q.push_back(8'hff);
    send_frame();
    build_frame(LINK_ETH, KIND_V4, '0, '1, HDR_ETH + IP4_HDR);
    send_frame();
    build_frame(LINK_ETH, KIND_V4, '1, '0, HDR_ETH + IP4_HDR - 1);
    send_frame();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) begin
        lt = 2'(p % 2);
        md = 3'(p);
      end else if (p == 8) begin
        lt = 2'd2;
        md = 3'($urandom_range(0, 6));
      end else if (p == 9) begin
        lt = 2'd3;
        md = MODE_ANY;
      end else begin
        lt = 2'($urandom_range(0, 1));
        md = 3'($urandom_range(MODE_V4_ONE, MODE_V6_PAIR));
      end
      style = (p == 3) ? 1 : (p == 4) ? 0 : 2;
      // The closing phases run without any idling.
      tx_gaps = (p < 10) && ($urandom_range(0, 3) != 0);
      rx_gaps = (p < 10) && ($urandom_range(0, 3) != 0);
      configure(lt, md, style);
      budget = sent_bytes + PHASE_BYTES;
      while (sent_bytes < budget) random_frame();
      drain();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
